### hdl/aal_pkg.sv
// Package for the address allow-list table.
// Holds request/result payload types, operation codes and controller links.
// No dependencies.
`default_nettype none

package aal_pkg;

  localparam int ENTRIES_DEFAULT = 64;
  localparam int ADDR_W = 32;
  localparam int SLOT_W = 6;
  localparam int COUNT_W = 7;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] address;
  } request_t;

  typedef struct packed {
    logic               hit;
    logic               table_full;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] active_count;
  } result_t;

  typedef struct packed {
    logic load;
    logic commit;
  } aal_cmd_t;

  typedef struct packed {
    logic out_free;
  } aal_sts_t;

endpackage

`default_nettype wire

### hdl/aal_ctrl.sv
// Controller for the address allow-list table.
// Sequences accept and commit of one request; uses aal_pkg.
`default_nettype none

module aal_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_stall,
  input  aal_pkg::aal_sts_t sts,
  output aal_pkg::aal_cmd_t cmd
);
  import aal_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_COMMIT = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd.load = 1'b0;
    cmd.commit = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (request_valid) begin
          cmd.load = 1'b1;
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign request_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### hdl/aal_dp.sv
// Datapath for the address allow-list table: entry registers, parallel
// compare, priority encoders, active count and result register; uses aal_pkg.
`default_nettype none

module aal_dp #(
  parameter int ENTRIES = aal_pkg::ENTRIES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  aal_pkg::request_t request,
  input  aal_pkg::aal_cmd_t cmd,
  output aal_pkg::aal_sts_t sts,
  output logic              result_valid,
  input  logic              result_stall,
  output aal_pkg::result_t  result
);
  import aal_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [ADDR_W-1:0]  addr_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [1:0]         req_kind;
  logic [ADDR_W-1:0]  req_addr;
  logic [ENTRIES-1:0] match_q;
  logic [ENTRIES-1:0] free_q;
  logic [CNT_W-1:0]   count;

  logic               match_any;
  logic               free_any;
  logic [IDX_W-1:0]   match_idx;
  logic [IDX_W-1:0]   free_idx;
  logic               wr_en;
  logic               clr_en;
  logic [CNT_W-1:0]   count_next;
  logic               hit_next;
  logic               full_next;
  logic [IDX_W-1:0]   slot_idx;
  logic [IDX_W+SLOT_W-1:0]  slot_ext;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  // Lowest set bit wins.
  always_comb begin
    match_idx = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        match_idx = IDX_W'(i);
      end
      if (free_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign match_any = |match_q;
  assign free_any = |free_q;

  always_comb begin
    wr_en = 1'b0;
    clr_en = 1'b0;
    hit_next = 1'b0;
    full_next = 1'b0;
    slot_idx = '0;
    count_next = count;
    unique case (req_kind)
      KIND_ADD: begin
        if (match_any) begin
          hit_next = 1'b1;
          slot_idx = match_idx;
        end else if (free_any) begin
          wr_en = 1'b1;
          slot_idx = free_idx;
          count_next = count + CNT_W'(1);
        end else begin
          full_next = 1'b1;
        end
      end
      KIND_QUERY: begin
        if (match_any) begin
          hit_next = 1'b1;
          slot_idx = match_idx;
        end
      end
      KIND_REMOVE: begin
        if (match_any) begin
          clr_en = 1'b1;
          hit_next = 1'b1;
          slot_idx = match_idx;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign slot_ext = {{SLOT_W{1'b0}}, slot_idx};
  assign count_ext = {{COUNT_W{1'b0}}, count_next};
  assign sts.out_free = !result_valid || !result_stall;

  // Capture request and compare against all entries.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind <= request.kind;
      req_addr <= request.address;
      for (int i = 0; i < ENTRIES; i++) begin
        match_q[i] <= valid_q[i] && (addr_q[i] == request.address);
      end
      free_q <= ~valid_q;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (cmd.commit && wr_en && (free_idx == IDX_W'(i))) begin
        addr_q[i] <= req_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
      for (int i = 0; i < ENTRIES; i++) begin
        if (wr_en && (free_idx == IDX_W'(i))) begin
          valid_q[i] <= 1'b1;
        end else if (clr_en && (match_idx == IDX_W'(i))) begin
          valid_q[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.hit <= hit_next;
      result.table_full <= full_next;
      result.slot <= slot_ext[SLOT_W-1:0];
      result.active_count <= count_ext[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### hdl/address_allow_list_table.sv
// Top level of the address allow-list table.
// Joins aal_ctrl and aal_dp; uses aal_pkg.
//
//   channel   direction  handshake                      payload
//   request   in         request_valid / request_stall  aal_pkg::request_t
//   result    out        result_valid / result_stall    aal_pkg::result_t
//
// A request passes an accept step and a commit step: accept registers the compare of the
// address against every entry; commit, which waits while a held result stalls, picks the
// lowest match or free slot, updates the table and loads the result register.
// The result register parts the two sides; a held result stalls only the
// commit step. Reset clears all valid marks and the count at once.
`default_nettype none

module address_allow_list_table #(
  parameter int ENTRIES = aal_pkg::ENTRIES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_stall,
  input  aal_pkg::request_t request,
  output logic              result_valid,
  input  logic              result_stall,
  output aal_pkg::result_t  result
);
  import aal_pkg::*;

  aal_cmd_t cmd;
  aal_sts_t sts;

  aal_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .sts           (sts),
    .cmd           (cmd)
  );

  aal_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire
